/* hdl/ntt_pkg.sv */
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types and constants of the neighbor tick table.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(1);

  // Mode codes as seen on the request channel
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_DELETE,
    OP_LOOKUP,
    OP_DUMP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] entry_addr;
    logic [TICK_W-1:0] tick_count;
    logic              status;
    logic              last;
  } rsp_t;

endpackage

/* hdl/ntt_if.sv */
// ----------------------------------------------------------------------------
// ntt_req_if / ntt_rsp_if
// Valid/ready channels of the neighbor tick table.
// ----------------------------------------------------------------------------
interface ntt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] neighbor_addr;

  modport source (output valid, output mode, output neighbor_addr, input ready);
  modport sink   (input valid, input mode, input neighbor_addr, output ready);
endinterface

interface ntt_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] entry_addr;
  logic [31:0] tick_count;
  logic        status;
  logic        last;

  modport source (output valid, output found, output entry_addr, output tick_count,
                  output status, output last, input ready);
  modport sink   (input valid, input found, input entry_addr, input tick_count,
                  input status, input last, output ready);
endinterface

/* hdl/neighbor_tick_table.sv */
// ----------------------------------------------------------------------------
// neighbor_tick_table
// Associative table of neighbor addresses with saturating tick counts.
//
// Each request beat carries a mode (tick, delete, lookup, dump) and an address.
// Tick, delete and lookup give one response beat each; in the table engine
// they pass a command pop, a registered parallel match of all slots that also
// fetches the matched count, and the execute step that updates the matched slot
// or fills a free one, waiting while the response register is still full. A dump
// walks the slots, at most TABLE_DEPTH, up to the last valid one after those steps, and
// gives one beat per valid slot in slot order with last set on the final beat;
// an empty table gives a single not-found beat. A two-entry command queue lets
// requests be taken while the engine works, and a response register lets the
// engine pop and match the next command while a finished beat waits downstream.
// The table is empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module neighbor_tick_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ntt_req_if.sink   req_i,
  ntt_rsp_if.source rsp_o
);
  import ntt_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  ntt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  ntt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  ntt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .rsp_o       (rsp_o)
  );

  // A beat that is not the last of a dump reports a stored entry
  a_dump_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.last |-> rsp_o.found && !rsp_o.status)
    else $error("non-final beat without a found entry");

  // A refused insertion stores nothing and reports no count
  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status |-> !rsp_o.found && (rsp_o.tick_count == '0) && rsp_o.last)
    else $error("full-table beat carries found or count");

  // A command cannot leave the queue while the engine is busy with the last one
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_valid && queue_ready |=> !queue_ready)
    else $error("engine took two commands back to back");

endmodule

/* hdl/ntt_front.sv */
// ----------------------------------------------------------------------------
// ntt_front
// Accepts request beats, decodes the mode and registers the command.
// ----------------------------------------------------------------------------
module ntt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ntt_req_if.sink       req_i,
  output ntt_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import ntt_pkg::*;

  logic stage_valid_q, stage_valid_d;
  cmd_t stage_q, stage_d;
  logic accept;

  assign req_i.ready = !stage_valid_q || cmd_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    stage_d.addr = req_i.neighbor_addr;
    case (req_i.mode)
      MODE_TICK:   stage_d.op = OP_TICK;
      MODE_DELETE: stage_d.op = OP_DELETE;
      MODE_LOOKUP: stage_d.op = OP_LOOKUP;
      MODE_DUMP: begin
        stage_d.op   = OP_DUMP;
        stage_d.addr = '0;  // address plays no part in a dump
      end
      default:     stage_d.op = OP_LOOKUP;
    endcase
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign cmd_o       = stage_q;
  assign cmd_valid_o = stage_valid_q;

endmodule

/* hdl/ntt_queue.sv */
// ----------------------------------------------------------------------------
// ntt_queue
// Short command queue between the front and the table engine.
// ----------------------------------------------------------------------------
module ntt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ntt_pkg::cmd_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output ntt_pkg::cmd_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import ntt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/ntt_back.sv */
// ----------------------------------------------------------------------------
// ntt_back
// Table engine: parallel address match, tick/delete/lookup and slot walk.
// ----------------------------------------------------------------------------
module ntt_back #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ntt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  ntt_rsp_if.source     rsp_o
);
  import ntt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC,
    S_DUMP
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic                   hit_q, free_q, any_q;
  logic [IDX_W-1:0]       hit_idx_q, free_idx_q, walk_idx_q;
  logic [TICK_W-1:0]      hit_tick_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  rsp_t                   rsp_q;
  logic                   rsp_valid_q;

  logic [ADDR_W-1:0]      addr_mem [TABLE_DEPTH];
  logic [TICK_W-1:0]      tick_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] hit_vec, above_vec;
  logic [IDX_W-1:0]       hit_idx, free_idx;
  logic [TICK_W-1:0]      tick_inc;
  logic                   out_free, walk_last, tick_write, tick_new;
  logic                   exec_step, dump_start, walk_hit, rsp_load;
  rsp_t                   exec_rsp;

  // Match every valid slot against the command address
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      hit_vec[j] = valid_q[j] && (addr_mem[j] == cmd_q.addr);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = IDX_W'(j);
      end
      if (!valid_q[j]) begin
        free_idx = IDX_W'(j);
      end
    end
  end

  // Valid slots beyond the walk position decide the last marker
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      above_vec[j] = valid_q[j] && (IDX_W'(j) > walk_idx_q);
    end
  end

  assign walk_last   = (above_vec == '0);
  assign tick_inc    = (hit_tick_q == TICK_MAX) ? hit_tick_q : hit_tick_q + TICK_ONE;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE);

  assign exec_step  = (state_q == S_EXEC) && out_free;
  assign dump_start = exec_step && (cmd_q.op == OP_DUMP) && any_q;
  assign walk_hit   = (state_q == S_DUMP) && valid_q[walk_idx_q];
  assign rsp_load   = (exec_step && !dump_start) || (walk_hit && out_free);

  assign tick_write = exec_step && (cmd_q.op == OP_TICK);
  assign tick_new   = tick_write && !hit_q && free_q;

  // Single-beat response of tick, delete, lookup and the empty dump
  always_comb begin
    exec_rsp.found      = hit_q;
    exec_rsp.entry_addr = cmd_q.addr;
    exec_rsp.tick_count = '0;
    exec_rsp.status     = 1'b0;
    exec_rsp.last       = 1'b1;
    case (cmd_q.op)
      OP_TICK: begin
        if (hit_q) begin
          exec_rsp.tick_count = tick_inc;
        end else if (free_q) begin
          exec_rsp.tick_count = TICK_ONE;
        end else begin
          exec_rsp.status = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit_q) begin
          exec_rsp.tick_count = hit_tick_q;
        end
      end
      OP_DUMP: begin
        // only reached with an empty table
        exec_rsp.found      = 1'b0;
        exec_rsp.entry_addr = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      any_q       <= 1'b0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      walk_idx_q  <= '0;
      hit_tick_q  <= '0;
      valid_q     <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_o.ready);
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_q      <= |hit_vec;
          hit_idx_q  <= hit_idx;
          hit_tick_q <= tick_mem[hit_idx];
          free_q     <= ~&valid_q;
          free_idx_q <= free_idx;
          any_q      <= |valid_q;
          walk_idx_q <= '0;
          state_q    <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            if (dump_start) begin
              state_q <= S_DUMP;
            end else begin
              rsp_q   <= exec_rsp;
              state_q <= S_IDLE;
            end
            if (tick_new) begin
              valid_q[free_idx_q] <= 1'b1;
            end else if ((cmd_q.op == OP_DELETE) && hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
          end
        end
        S_DUMP: begin
          if (!valid_q[walk_idx_q]) begin
            walk_idx_q <= walk_idx_q + IDX_W'(1);
          end else if (out_free) begin
            rsp_q.found      <= 1'b1;
            rsp_q.entry_addr <= addr_mem[walk_idx_q];
            rsp_q.tick_count <= tick_mem[walk_idx_q];
            rsp_q.status     <= 1'b0;
            rsp_q.last       <= walk_last;
            if (walk_last) begin
              state_q <= S_IDLE;
            end else begin
              walk_idx_q <= walk_idx_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_new) begin
      addr_mem[free_idx_q] <= cmd_q.addr;
      tick_mem[free_idx_q] <= TICK_ONE;
    end else if (tick_write && hit_q) begin
      tick_mem[hit_idx_q] <= tick_inc;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.found      = rsp_q.found;
  assign rsp_o.entry_addr = rsp_q.entry_addr;
  assign rsp_o.tick_count = rsp_q.tick_count;
  assign rsp_o.status     = rsp_q.status;
  assign rsp_o.last       = rsp_q.last;

endmodule
